[src/assert_macros.svh]
// Assertion macros shared by the rotator RTL.
// Bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property, skipped while reset is asserted.
`define PAVR_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: property failed");
// Implication form: antecedent in this cycle, consequent in the same cycle.
`define PAVR_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: implication failed");
`else
`define PAVR_ASSERT(lbl, clk, rstn, prop)
`define PAVR_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif
`endif

[src/pavr_pkg.sv]
// Package for the pose aware velocity rotator: sizes, register codes,
// controller/datapath command structs and the CORDIC arctangent table.
`timescale 1ns / 1ps

package pavr_pkg;

    localparam int MAX_ROBOTS   = 16;
    localparam int CORDIC_STEPS = 16;

    localparam int ID_W     = 4;
    localparam int ID_AW    = (MAX_ROBOTS > 1) ? $clog2(MAX_ROBOTS) : 1;
    localparam int STEP_W   = $clog2(CORDIC_STEPS);
    localparam int POS_W    = 14;
    localparam int HEAD_W   = 16;
    localparam int VEL_W    = 14;
    localparam int OUT_W    = 15;
    localparam int POSE_W   = 2 * POS_W + HEAD_W;
    localparam int ACC_W    = 32;
    localparam int GAIN_W   = 30;
    localparam int Z_SHIFT  = 16;
    localparam int ATAN_IW  = 5;
    localparam int RND_SHIFT = 16;

    localparam int XL_W     = 13;
    localparam int YL_W     = 13;
    localparam int MARGIN_W = 10;
    localparam int PUSH_W   = 13;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 13;

    // CORDIC gain compensation, Q30
    localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;

    // Command codes
    localparam logic CMD_POSE = 1'b0;
    localparam logic CMD_VEL  = 1'b1;

    // Register indexes
    localparam logic [CFG_AW-1:0] CFG_AREA_X_LIMIT = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_AREA_Y_LIMIT = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_PUSH_MARGIN  = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_PUSH_SPEED   = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_KEEPER_ID    = 3'd4;

    // Register reset values
    localparam logic [XL_W-1:0]     AREA_X_LIMIT_RST = 13'd1590;
    localparam logic [YL_W-1:0]     AREA_Y_LIMIT_RST = 13'd785;
    localparam logic [MARGIN_W-1:0] PUSH_MARGIN_RST  = 10'd30;
    localparam logic [PUSH_W-1:0]   PUSH_SPEED_RST   = 13'd307;
    localparam logic [ID_W-1:0]     KEEPER_ID_RST    = 4'd0;

    typedef struct packed {
        logic              capture;
        logic              limit;
        logic              scale;
        logic              iter;
        logic [STEP_W-1:0] step;
        logic              emit;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_sts_t;

    // atan(2^-i), 2^32 units per turn
    function automatic logic signed [ACC_W-1:0] atan_lut(input logic [ATAN_IW-1:0] idx);
        logic signed [ACC_W-1:0] v;
        case (idx)
            5'd0:    v = 32'sd536870912;
            5'd1:    v = 32'sd316933406;
            5'd2:    v = 32'sd167458907;
            5'd3:    v = 32'sd85004756;
            5'd4:    v = 32'sd42667331;
            5'd5:    v = 32'sd21354465;
            5'd6:    v = 32'sd10679838;
            5'd7:    v = 32'sd5340245;
            5'd8:    v = 32'sd2670163;
            5'd9:    v = 32'sd1335087;
            5'd10:   v = 32'sd667544;
            5'd11:   v = 32'sd333772;
            5'd12:   v = 32'sd166886;
            5'd13:   v = 32'sd83443;
            5'd14:   v = 32'sd41722;
            5'd15:   v = 32'sd20861;
            5'd16:   v = 32'sd10430;
            5'd17:   v = 32'sd5215;
            5'd18:   v = 32'sd2608;
            5'd19:   v = 32'sd1304;
            5'd20:   v = 32'sd652;
            5'd21:   v = 32'sd326;
            5'd22:   v = 32'sd163;
            5'd23:   v = 32'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[src/pavr_ram.sv]
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module pavr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    aclk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/pavr_ctrl.sv]
// Sequencer for the rotator: accept, limit, scale, CORDIC iterations, emit.
// Depends on pavr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pavr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_cmd,
    output logic              s_ready,
    output pavr_pkg::dp_cmd_t cmd,
    input  pavr_pkg::dp_sts_t sts
);
    import pavr_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LIMIT  = 3'd1;
    localparam logic [2:0] ST_SCALE  = 3'd2;
    localparam logic [2:0] ST_ITER   = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              accept;

    // hold off input while reset is asserted
    assign s_ready = aresetn && (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_cmd == CMD_VEL)) begin
                    state_next = ST_LIMIT;
                end
            end
            ST_LIMIT: begin
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                state_next = ST_ITER;
                step_next  = '0;
            end
            ST_ITER: begin
                if (step_reg == STEP_LAST) begin
                    state_next = ST_FINISH;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_FINISH: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        cmd.capture = accept;
        cmd.limit   = (state_reg == ST_LIMIT);
        cmd.scale   = (state_reg == ST_SCALE);
        cmd.iter    = (state_reg == ST_ITER);
        cmd.step    = step_reg;
        cmd.emit    = (state_reg == ST_FINISH) && sts.out_free;
    end

    `PAVR_ASSERT(a_busy_after_vel, aclk, aresetn, s_valid && s_ready && (s_cmd == CMD_VEL) |=> !s_ready)
    `PAVR_ASSERT(a_iter_starts_at_zero, aclk, aresetn, cmd.scale |=> cmd.iter && (cmd.step == '0))
    `PAVR_ASSERT_IMPL(a_no_accept_while_busy, aclk, aresetn, cmd.iter || cmd.limit || cmd.scale, !s_ready)

endmodule

[src/pavr_dp.sv]
// Datapath for the rotator: registers, pose table, keep-out limiter,
// gain scaling, shared CORDIC shift-add unit and output register.
// Depends on pavr_pkg, pavr_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pavr_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [pavr_pkg::CFG_AW-1:0]         cfg_addr,
    input  logic [pavr_pkg::CFG_DW-1:0]         cfg_wdata,
    input  logic                                s_cmd,
    input  logic [pavr_pkg::ID_W-1:0]           s_robot_num,
    input  logic signed [pavr_pkg::POS_W-1:0]   s_pos_x,
    input  logic signed [pavr_pkg::POS_W-1:0]   s_pos_y,
    input  logic signed [pavr_pkg::HEAD_W-1:0]  s_heading,
    input  logic signed [pavr_pkg::VEL_W-1:0]   s_vel_x,
    input  logic signed [pavr_pkg::VEL_W-1:0]   s_vel_y,
    input  logic signed [pavr_pkg::VEL_W-1:0]   s_ang_vel,
    input  pavr_pkg::dp_cmd_t                   cmd,
    output pavr_pkg::dp_sts_t                   sts,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [pavr_pkg::ID_W-1:0]           m_out_robot_num,
    output logic signed [pavr_pkg::OUT_W-1:0]   m_fwd_vel,
    output logic signed [pavr_pkg::OUT_W-1:0]   m_left_vel,
    output logic signed [pavr_pkg::VEL_W-1:0]   m_out_ang_vel
);
    import pavr_pkg::*;

    localparam int PROD_W = VEL_W + GAIN_W + 1;
    localparam int RND_W  = ACC_W + 1;
    localparam logic signed [HEAD_W-1:0] QUARTER = HEAD_W'(longint'(1) <<< (HEAD_W - 2));
    localparam logic signed [ACC_W-1:0] Z_LIMIT =
        ACC_W'(longint'(1) <<< (HEAD_W - 2 + Z_SHIFT));
    localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(longint'(1) <<< (RND_SHIFT - 1));
    localparam logic signed [RND_W-1:0] SAT_HI = RND_W'((longint'(1) <<< (OUT_W - 1)) - 1);
    localparam logic signed [RND_W-1:0] SAT_LO = RND_W'(-(longint'(1) <<< (OUT_W - 1)));

    // Configuration registers
    logic [XL_W-1:0]     area_x_limit_reg;
    logic [YL_W-1:0]     area_y_limit_reg;
    logic [MARGIN_W-1:0] push_margin_reg;
    logic [PUSH_W-1:0]   push_speed_reg;
    logic [ID_W-1:0]     keeper_id_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            area_x_limit_reg <= AREA_X_LIMIT_RST;
            area_y_limit_reg <= AREA_Y_LIMIT_RST;
            push_margin_reg  <= PUSH_MARGIN_RST;
            push_speed_reg   <= PUSH_SPEED_RST;
            keeper_id_reg    <= KEEPER_ID_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_AREA_X_LIMIT: area_x_limit_reg <= cfg_wdata[XL_W-1:0];
                CFG_AREA_Y_LIMIT: area_y_limit_reg <= cfg_wdata[YL_W-1:0];
                CFG_PUSH_MARGIN:  push_margin_reg  <= cfg_wdata[MARGIN_W-1:0];
                CFG_PUSH_SPEED:   push_speed_reg   <= cfg_wdata[PUSH_W-1:0];
                CFG_KEEPER_ID:    keeper_id_reg    <= cfg_wdata[ID_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Pose table
    logic              in_table;
    logic [ID_AW-1:0]  s_addr;
    logic              ram_we;
    logic [POSE_W-1:0] ram_rdata;
    logic [MAX_ROBOTS-1:0] known_reg;

    assign in_table = (int'(s_robot_num) < MAX_ROBOTS);
    assign s_addr   = ID_AW'(s_robot_num);
    assign ram_we   = cmd.capture && (s_cmd == CMD_POSE) && in_table;

    pavr_ram #(
        .WIDTH (POSE_W),
        .DEPTH (MAX_ROBOTS)
    ) u_pose_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (s_addr),
        .wr_data ({s_pos_x, s_pos_y, s_heading}),
        .rd_en   (cmd.capture),
        .rd_addr (s_addr),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            known_reg <= '0;
        end else if (ram_we) begin
            known_reg[s_addr] <= 1'b1;
        end
    end

    // Command capture
    logic [ID_W-1:0]          id_reg;
    logic signed [VEL_W-1:0]  vx_reg, vy_reg, ang_reg;
    logic                     use_pose_reg;
    logic signed [HEAD_W-1:0] theta_reg;

    // Keep-out limiter
    logic signed [POS_W-1:0]  rx, ry;
    logic signed [HEAD_W-1:0] rh;
    logic signed [15:0]       rx16, ry16, ary16, xl16, yl16, deep16;
    logic signed [VEL_W-1:0]  push_v, vx_lim;
    logic                     is_keeper, pos_on, neg_on, pos_box, neg_box;

    assign rx = $signed(ram_rdata[POSE_W-1 -: POS_W]);
    assign ry = $signed(ram_rdata[HEAD_W +: POS_W]);
    assign rh = $signed(ram_rdata[HEAD_W-1:0]);

    always_comb begin
        rx16      = 16'(rx);
        ry16      = 16'(ry);
        ary16     = (ry16 < 0) ? -ry16 : ry16;
        xl16      = $signed({3'b000, area_x_limit_reg});
        yl16      = $signed({3'b000, area_y_limit_reg});
        deep16    = xl16 + $signed({6'b000000, push_margin_reg});
        push_v    = $signed({1'b0, push_speed_reg});
        is_keeper = (id_reg == keeper_id_reg);
        pos_on    = !(is_keeper && (rx16 > 0));
        neg_on    = !(is_keeper && !(rx16 > 0));
        pos_box   = pos_on && (rx16 >= xl16) && (ary16 < yl16);
        neg_box   = neg_on && (rx16 <= -xl16) && (ary16 < yl16);
        vx_lim    = vx_reg;
        if (pos_box) begin
            if (vx_lim > 0) begin
                vx_lim = '0;
            end
            if (rx16 > deep16) begin
                vx_lim = -push_v;
            end
        end
        if (neg_box) begin
            if (vx_lim < 0) begin
                vx_lim = '0;
            end
            if (rx16 < -deep16) begin
                vx_lim = push_v;
            end
        end
    end

    // Gain scaling and half-turn fold
    logic signed [PROD_W-1:0] px, py;
    logic signed [ACC_W-1:0]  xs, ys;
    logic signed [HEAD_W-1:0] phi0, phi;
    logic                     fold;

    always_comb begin
        px   = vx_reg * $signed({1'b0, GAIN_Q30});
        py   = vy_reg * $signed({1'b0, GAIN_Q30});
        xs   = ACC_W'(px >>> 14);
        ys   = ACC_W'(py >>> 14);
        phi0 = -theta_reg;
        fold = (phi0 > QUARTER) || (phi0 < -QUARTER);
        phi  = fold ? {~phi0[HEAD_W-1], phi0[HEAD_W-2:0]} : phi0;
    end

    // CORDIC shift-add unit
    logic signed [ACC_W-1:0] x_reg, y_reg, z_reg;
    logic signed [ACC_W-1:0] dx, dy, at;

    always_comb begin
        dx = y_reg >>> cmd.step;
        dy = x_reg >>> cmd.step;
        at = atan_lut(ATAN_IW'(cmd.step));
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            id_reg       <= s_robot_num;
            vx_reg       <= s_vel_x;
            vy_reg       <= s_vel_y;
            ang_reg      <= s_ang_vel;
            use_pose_reg <= in_table && known_reg[s_addr];
        end else if (cmd.limit) begin
            if (use_pose_reg) begin
                vx_reg    <= vx_lim;
                theta_reg <= rh;
            end else begin
                theta_reg <= '0;
            end
        end
        if (cmd.scale) begin
            x_reg <= fold ? -xs : xs;
            y_reg <= fold ? -ys : ys;
            z_reg <= $signed({phi, Z_SHIFT'(0)});
        end else if (cmd.iter) begin
            if (z_reg >= 0) begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at;
            end else begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at;
            end
        end
    end

    // Round, saturate and hold the result
    logic signed [RND_W-1:0] rx_sum, ry_sum, rx_sh, ry_sh;
    logic signed [OUT_W-1:0] fwd_sat, left_sat;

    always_comb begin
        rx_sum = RND_W'(x_reg) + RND_HALF;
        ry_sum = RND_W'(y_reg) + RND_HALF;
        rx_sh  = rx_sum >>> RND_SHIFT;
        ry_sh  = ry_sum >>> RND_SHIFT;
        if (rx_sh > SAT_HI) begin
            fwd_sat = OUT_W'(SAT_HI);
        end else if (rx_sh < SAT_LO) begin
            fwd_sat = OUT_W'(SAT_LO);
        end else begin
            fwd_sat = OUT_W'(rx_sh);
        end
        if (ry_sh > SAT_HI) begin
            left_sat = OUT_W'(SAT_HI);
        end else if (ry_sh < SAT_LO) begin
            left_sat = OUT_W'(SAT_LO);
        end else begin
            left_sat = OUT_W'(ry_sh);
        end
    end

    logic                    m_valid_reg;
    logic [ID_W-1:0]         m_id_reg;
    logic signed [OUT_W-1:0] m_fwd_reg, m_left_reg;
    logic signed [VEL_W-1:0] m_ang_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_id_reg   <= id_reg;
            m_fwd_reg  <= fwd_sat;
            m_left_reg <= left_sat;
            m_ang_reg  <= ang_reg;
        end
    end

    assign sts.out_free    = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_out_robot_num = m_id_reg;
    assign m_fwd_vel       = m_fwd_reg;
    assign m_left_vel      = m_left_reg;
    assign m_out_ang_vel   = m_ang_reg;

    `PAVR_ASSERT(a_emit_fills_output, aclk, aresetn, cmd.emit |=> m_valid)
    `PAVR_ASSERT(a_angle_folded, aclk, aresetn, cmd.scale |=> (z_reg <= Z_LIMIT) && (z_reg >= -Z_LIMIT))
    `PAVR_ASSERT(a_result_held, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_fwd_vel))

endmodule

[src/pose_aware_velocity_rotator_top.sv]
// Top level of the pose aware velocity rotator.
// Depends on pavr_pkg, pavr_ctrl, pavr_dp (and pavr_ram below it).
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// s_*       in         s_valid / s_ready  cmd, robot_num, pos_x, pos_y, heading,
//                                         vel_x, vel_y, ang_vel
// m_*       out        m_valid / m_ready  out_robot_num, fwd_vel, left_vel, out_ang_vel
// cfg_*     in         cfg_wr_en          cfg_addr, cfg_wdata (no read-back)
//
// A pose update yields no result transaction.
// A velocity command runs through these steps before the next transaction can be
// accepted: capture and table read, keep-out limit, gain scale, one CORDIC
// iteration per cycle in the shared shift-add unit, then round and load into the
// output register.
// The output register holds a result while m_ready is low; a new transaction is
// accepted meanwhile and only its final load waits for the register to free up.
// aresetn is synchronous, active low: it clears the sequencer, the known flags, the
// output valid and the configuration, and holds s_ready low; the pose table itself
// is not cleared.

module pose_aware_velocity_rotator_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [pavr_pkg::CFG_AW-1:0]         cfg_addr,
    input  logic [pavr_pkg::CFG_DW-1:0]         cfg_wdata,
    // input transactions
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_cmd,
    input  logic [pavr_pkg::ID_W-1:0]           s_robot_num,
    input  logic signed [pavr_pkg::POS_W-1:0]   s_pos_x,
    input  logic signed [pavr_pkg::POS_W-1:0]   s_pos_y,
    input  logic signed [pavr_pkg::HEAD_W-1:0]  s_heading,
    input  logic signed [pavr_pkg::VEL_W-1:0]   s_vel_x,
    input  logic signed [pavr_pkg::VEL_W-1:0]   s_vel_y,
    input  logic signed [pavr_pkg::VEL_W-1:0]   s_ang_vel,
    // result transactions
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [pavr_pkg::ID_W-1:0]           m_out_robot_num,
    output logic signed [pavr_pkg::OUT_W-1:0]   m_fwd_vel,
    output logic signed [pavr_pkg::OUT_W-1:0]   m_left_vel,
    output logic signed [pavr_pkg::VEL_W-1:0]   m_out_ang_vel
);
    import pavr_pkg::*;

    // Commands from the sequencer, status back from the datapath
    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;

    // Sequencer: owns s_ready, steps the datapath through each command
    pavr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_cmd   (s_cmd),
        .s_ready (s_ready),
        .cmd     (dp_cmd),
        .sts     (dp_sts)
    );

    // Datapath: config, pose table, limiter, CORDIC, output register
    pavr_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_cmd           (s_cmd),
        .s_robot_num     (s_robot_num),
        .s_pos_x         (s_pos_x),
        .s_pos_y         (s_pos_y),
        .s_heading       (s_heading),
        .s_vel_x         (s_vel_x),
        .s_vel_y         (s_vel_y),
        .s_ang_vel       (s_ang_vel),
        .cmd             (dp_cmd),
        .sts             (dp_sts),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_robot_num (m_out_robot_num),
        .m_fwd_vel       (m_fwd_vel),
        .m_left_vel      (m_left_vel),
        .m_out_ang_vel   (m_out_ang_vel)
    );

endmodule
